// ===== hw/rtl/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg: shared definitions for the printf specifier parser
// Character codes, classification types and the packed result layout.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int VALUE_BITS_DEFAULT = 16;
	localparam int OUT_VALUE_BITS     = 16;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_J     = 8'h6A;
	localparam logic [7:0] CH_Z     = 8'h7A;

	localparam logic [3:0] DIGIT_SCALE = 4'd10;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_DIGIT = 2'd1,
		CLS_DOT   = 2'd2
	} byte_class_t;

	typedef enum logic [1:0] {
		RUN_NONE  = 2'd0,
		RUN_WIDTH = 2'd1,
		RUN_PREC  = 2'd2
	} run_kind_t;

	typedef enum logic [2:0] {
		SIZE_NONE = 3'd0,
		SIZE_HH   = 3'd1,
		SIZE_H    = 3'd2,
		SIZE_LL   = 3'd3,
		SIZE_L    = 3'd4,
		SIZE_J    = 3'd5,
		SIZE_Z    = 3'd6
	} size_mod_t;

	// Flag bit positions.
	localparam int FLAG_HASH  = 0;
	localparam int FLAG_MINUS = 1;
	localparam int FLAG_ZERO  = 2;
	localparam int FLAG_PLUS  = 3;
	localparam int FLAG_SPACE = 4;

	// Length letter mark positions.
	localparam int MARK_H_SEEN = 0;
	localparam int MARK_H_ODD  = 1;
	localparam int MARK_L_SEEN = 2;
	localparam int MARK_L_ODD  = 3;
	localparam int MARK_J_SEEN = 4;
	localparam int MARK_Z_SEEN = 5;

	// Declared from the top bit down, so alt_form lands in bit 0.
	typedef struct packed {
		logic [7:0]                conversion;
		size_mod_t                 size_modifier;
		logic                      precision_given;
		logic [OUT_VALUE_BITS-1:0] precision;
		logic                      width_given;
		logic [OUT_VALUE_BITS-1:0] width;
		logic                      space_sign;
		logic                      force_sign;
		logic                      zero_pad;
		logic                      left_justify;
		logic                      alt_form;
	} result_t;

	localparam int RESULT_BITS = $bits(result_t);
	localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

endpackage

// ===== hw/rtl/printf_spec_parser.sv =====
// ----------------------------------------------------------------------------
// printf_spec_parser: printf conversion specifier parser
// Collects flags, width, precision and length modifier of one specifier.
// ----------------------------------------------------------------------------
// The slave stream carries the specifier bytes that follow the percent sign,
// one byte per item; tlast marks the conversion character. Every accepted
// byte updates the flag, digit and letter registers in the same cycle, so
// one byte is taken every cycle while the skid register is empty. The item
// with tlast set loads one result into the output register, or into the skid
// register when the output register is stalled, and clears the parse state
// for the next specifier. The rate is set by the single update path: one
// multiply by ten, an add and a saturating compare on the accumulator.
// When the receiver stalls, the result waits in the output register while
// further bytes keep flowing in; a second finished result is held in a skid
// register, and only then does s_axis_tready drop until the master side
// drains. Reset clears all parse state and both output valid flags.
// ----------------------------------------------------------------------------
module printf_spec_parser #(
	parameter int VALUE_BITS = psp_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // spec_byte
	input  logic                            s_axis_tlast,  // last_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// alt_form, left_justify, zero_pad, force_sign, space_sign, width[15:0],
	// width_given, precision[15:0], precision_given, size_modifier[2:0],
	// conversion[7:0], zero fill
	output logic [psp_pkg::TDATA_BITS-1:0]  m_axis_tdata
);

	localparam int ACC_BITS = (VALUE_BITS > psp_pkg::OUT_VALUE_BITS) ?
		psp_pkg::OUT_VALUE_BITS : VALUE_BITS;
	localparam int SUM_BITS = ACC_BITS + 4;
	localparam logic [SUM_BITS-1:0] ACC_LIMIT =
		SUM_BITS'((64'd1 << ACC_BITS) - 64'd1);

	logic [4:0]                flags_q;
	logic [ACC_BITS-1:0]       width_q;
	logic                      width_seen_q;
	logic [ACC_BITS-1:0]       prec_q;
	logic                      dot_seen_q;
	psp_pkg::byte_class_t      prev_q;
	psp_pkg::run_kind_t        run_q;
	logic [5:0]                marks_q;

	logic [4:0]                flags_d;
	logic [ACC_BITS-1:0]       width_d;
	logic                      width_seen_d;
	logic [ACC_BITS-1:0]       prec_d;
	logic                      dot_seen_d;
	psp_pkg::byte_class_t      prev_d;
	psp_pkg::run_kind_t        run_d;
	logic [5:0]                marks_d;

	psp_pkg::result_t          res_q;
	logic                      res_valid_q;
	psp_pkg::result_t          skid_q;
	logic                      skid_valid_q;
	psp_pkg::result_t          res_new;
	psp_pkg::size_mod_t        size_code;

	logic                      in_acc;
	logic                      push;
	logic                      is_digit;
	logic [7:0]                digit_full;
	logic [3:0]                digit;
	logic                      to_prec;
	logic                      to_width;
	logic [ACC_BITS-1:0]       acc_base;
	logic [SUM_BITS-1:0]       acc_sum;
	logic [ACC_BITS-1:0]       acc_sat;

	assign s_axis_tready = !skid_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign push          = in_acc && s_axis_tlast;

	assign is_digit   = s_axis_tdata inside {[psp_pkg::CH_ZERO:psp_pkg::CH_NINE]};
	assign digit_full = s_axis_tdata - psp_pkg::CH_ZERO;
	assign digit      = digit_full[3:0];

	assign to_prec  = (prev_q == psp_pkg::CLS_DOT) ||
		((prev_q == psp_pkg::CLS_DIGIT) && (run_q == psp_pkg::RUN_PREC));
	assign to_width = (prev_q == psp_pkg::CLS_DIGIT) && (run_q == psp_pkg::RUN_WIDTH);

	always_comb begin
		if (to_prec) begin
			acc_base = prec_q;
		end else if (to_width) begin
			acc_base = width_q;
		end else begin
			acc_base = '0;
		end
	end

	assign acc_sum = SUM_BITS'(acc_base) * SUM_BITS'(psp_pkg::DIGIT_SCALE) + SUM_BITS'(digit);
	assign acc_sat = (acc_sum > ACC_LIMIT) ? ACC_LIMIT[ACC_BITS-1:0] : acc_sum[ACC_BITS-1:0];

	always_comb begin
		size_code = psp_pkg::SIZE_NONE;
		if (marks_q[psp_pkg::MARK_Z_SEEN]) begin
			size_code = psp_pkg::SIZE_Z;
		end else if (marks_q[psp_pkg::MARK_J_SEEN]) begin
			size_code = psp_pkg::SIZE_J;
		end else if (marks_q[psp_pkg::MARK_L_SEEN]) begin
			size_code = marks_q[psp_pkg::MARK_L_ODD] ? psp_pkg::SIZE_L : psp_pkg::SIZE_LL;
		end else if (marks_q[psp_pkg::MARK_H_SEEN]) begin
			size_code = marks_q[psp_pkg::MARK_H_ODD] ? psp_pkg::SIZE_H : psp_pkg::SIZE_HH;
		end
	end

	always_comb begin
		res_new.alt_form        = flags_q[psp_pkg::FLAG_HASH];
		res_new.left_justify    = flags_q[psp_pkg::FLAG_MINUS];
		res_new.zero_pad        = flags_q[psp_pkg::FLAG_ZERO];
		res_new.force_sign      = flags_q[psp_pkg::FLAG_PLUS];
		res_new.space_sign      = flags_q[psp_pkg::FLAG_SPACE];
		res_new.width           = psp_pkg::OUT_VALUE_BITS'(width_q);
		res_new.width_given     = width_seen_q;
		res_new.precision       = psp_pkg::OUT_VALUE_BITS'(prec_q);
		res_new.precision_given = dot_seen_q;
		res_new.size_modifier   = size_code;
		res_new.conversion      = s_axis_tdata;
	end

	always_comb begin
		flags_d      = flags_q;
		width_d      = width_q;
		width_seen_d = width_seen_q;
		prec_d       = prec_q;
		dot_seen_d   = dot_seen_q;
		prev_d       = prev_q;
		run_d        = run_q;
		marks_d      = marks_q;
		if (s_axis_tlast) begin
			flags_d      = '0;
			width_d      = '0;
			width_seen_d = 1'b0;
			prec_d       = '0;
			dot_seen_d   = 1'b0;
			prev_d       = psp_pkg::CLS_OTHER;
			run_d        = psp_pkg::RUN_NONE;
			marks_d      = '0;
		end else if (is_digit) begin
			prev_d = psp_pkg::CLS_DIGIT;
			if (to_prec) begin
				run_d  = psp_pkg::RUN_PREC;
				prec_d = acc_sat;
			end else if (to_width) begin
				width_d = acc_sat;
			end else begin
				if (prev_q == psp_pkg::CLS_OTHER) begin
					run_d = psp_pkg::RUN_NONE;
					if (digit == 4'd0) begin
						flags_d[psp_pkg::FLAG_ZERO] = 1'b1;
					end
				end
				if (digit != 4'd0) begin
					run_d        = psp_pkg::RUN_WIDTH;
					width_seen_d = 1'b1;
					width_d      = acc_sat;
				end
			end
		end else if (s_axis_tdata == psp_pkg::CH_DOT) begin
			dot_seen_d = 1'b1;
			prec_d     = '0;
			run_d      = psp_pkg::RUN_NONE;
			prev_d     = psp_pkg::CLS_DOT;
		end else begin
			run_d  = psp_pkg::RUN_NONE;
			prev_d = psp_pkg::CLS_OTHER;
			case (s_axis_tdata)
				psp_pkg::CH_HASH: begin
					flags_d[psp_pkg::FLAG_HASH] = 1'b1;
				end
				psp_pkg::CH_MINUS: begin
					flags_d[psp_pkg::FLAG_MINUS] = 1'b1;
				end
				psp_pkg::CH_PLUS: begin
					flags_d[psp_pkg::FLAG_PLUS] = 1'b1;
				end
				psp_pkg::CH_SPACE: begin
					flags_d[psp_pkg::FLAG_SPACE] = 1'b1;
				end
				psp_pkg::CH_H: begin
					marks_d[psp_pkg::MARK_H_SEEN] = 1'b1;
					marks_d[psp_pkg::MARK_H_ODD]  = !marks_q[psp_pkg::MARK_H_ODD];
				end
				psp_pkg::CH_L: begin
					marks_d[psp_pkg::MARK_L_SEEN] = 1'b1;
					marks_d[psp_pkg::MARK_L_ODD]  = !marks_q[psp_pkg::MARK_L_ODD];
				end
				psp_pkg::CH_J: begin
					marks_d[psp_pkg::MARK_J_SEEN] = 1'b1;
				end
				psp_pkg::CH_Z: begin
					marks_d[psp_pkg::MARK_Z_SEEN] = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			width_q      <= '0;
			width_seen_q <= 1'b0;
			prec_q       <= '0;
			dot_seen_q   <= 1'b0;
			prev_q       <= psp_pkg::CLS_OTHER;
			run_q        <= psp_pkg::RUN_NONE;
			marks_q      <= '0;
		end else if (in_acc) begin
			flags_q      <= flags_d;
			width_q      <= width_d;
			width_seen_q <= width_seen_d;
			prec_q       <= prec_d;
			dot_seen_q   <= dot_seen_d;
			prev_q       <= prev_d;
			run_q        <= run_d;
			marks_q      <= marks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || m_axis_tready) begin
			res_q <= skid_valid_q ? skid_q : res_new;
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = psp_pkg::TDATA_BITS'(res_q);

endmodule

// ===== verif/printf_spec_parser_test.sv =====
// ----------------------------------------------------------------------------
// printf_spec_parser_test: self-checking bench for the specifier parser
// Feeds printf specifier bytes on the slave stream, predicts each result
// in a behavioral model of the parser, and compares every output item
// field by field, under random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module printf_spec_parser_test;

	localparam int VALUE_BITS  = psp_pkg::VALUE_BITS_DEFAULT;
	localparam int unsigned VALUE_CAP = (VALUE_BITS >= 16) ? 32'd65535 :
		(32'd1 << VALUE_BITS) - 32'd1;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata = 8'd0;  // spec_byte
	logic                           s_axis_tlast = 1'b0;  // last_byte
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// alt_form, left_justify, zero_pad, force_sign, space_sign, width,
	// width_given, precision, precision_given, size_modifier, conversion
	logic [psp_pkg::TDATA_BITS-1:0] m_axis_tdata;

	// Parser state of the behavioral model.
	logic [4:0]           flag_bits;
	logic [15:0]          width_acc;
	logic                 width_seen;
	logic [15:0]          prec_acc;
	logic                 dot_seen;
	psp_pkg::byte_class_t prev_cls;
	psp_pkg::run_kind_t   run_kind;
	logic [5:0]           letter_marks;

	psp_pkg::result_t spec_results_q[$];

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int bytes_sent = 0;
	int specs_sent = 0;
	int results_checked = 0;
	int fault_count = 0;
	int quiet_cycles = 0;

	printf_spec_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] times_ten_plus(logic [15:0] v, logic [3:0] d);
		int unsigned r;
		r = 32'(v) * 32'd10 + 32'(d);
		if (r > VALUE_CAP)
			r = VALUE_CAP;
		return r[15:0];
	endfunction

	function automatic psp_pkg::size_mod_t size_now();
		psp_pkg::size_mod_t code;
		code = psp_pkg::SIZE_NONE;
		if (letter_marks[psp_pkg::MARK_H_SEEN])
			code = letter_marks[psp_pkg::MARK_H_ODD] ? psp_pkg::SIZE_H : psp_pkg::SIZE_HH;
		if (letter_marks[psp_pkg::MARK_L_SEEN])
			code = letter_marks[psp_pkg::MARK_L_ODD] ? psp_pkg::SIZE_L : psp_pkg::SIZE_LL;
		if (letter_marks[psp_pkg::MARK_J_SEEN])
			code = psp_pkg::SIZE_J;
		if (letter_marks[psp_pkg::MARK_Z_SEEN])
			code = psp_pkg::SIZE_Z;
		return code;
	endfunction

	task automatic clear_parse();
		flag_bits = '0;
		width_acc = '0;
		width_seen = 1'b0;
		prec_acc = '0;
		dot_seen = 1'b0;
		prev_cls = psp_pkg::CLS_OTHER;
		run_kind = psp_pkg::RUN_NONE;
		letter_marks = '0;
	endtask

	task automatic parse_byte(logic [7:0] b, logic last);
		psp_pkg::result_t r;
		logic [3:0] d;
		r = '0;
		d = 4'(b - psp_pkg::CH_ZERO);
		if (last) begin
			r.alt_form = flag_bits[psp_pkg::FLAG_HASH];
			r.left_justify = flag_bits[psp_pkg::FLAG_MINUS];
			r.zero_pad = flag_bits[psp_pkg::FLAG_ZERO];
			r.force_sign = flag_bits[psp_pkg::FLAG_PLUS];
			r.space_sign = flag_bits[psp_pkg::FLAG_SPACE];
			r.width = width_acc;
			r.width_given = width_seen;
			r.precision = prec_acc;
			r.precision_given = dot_seen;
			r.size_modifier = size_now();
			r.conversion = b;
			spec_results_q.push_back(r);
			specs_sent++;
			clear_parse();
		end else if (b >= psp_pkg::CH_ZERO && b <= psp_pkg::CH_NINE) begin
			if (prev_cls == psp_pkg::CLS_DOT) begin
				run_kind = psp_pkg::RUN_PREC;
				prec_acc = times_ten_plus(prec_acc, d);
			end else if (prev_cls == psp_pkg::CLS_DIGIT && run_kind == psp_pkg::RUN_PREC) begin
				prec_acc = times_ten_plus(prec_acc, d);
			end else if (prev_cls == psp_pkg::CLS_DIGIT && run_kind == psp_pkg::RUN_WIDTH) begin
				width_acc = times_ten_plus(width_acc, d);
			end else begin
				if (prev_cls == psp_pkg::CLS_OTHER) begin
					run_kind = psp_pkg::RUN_NONE;
					if (d == 4'd0)
						flag_bits[psp_pkg::FLAG_ZERO] = 1'b1;
				end
				if (d != 4'd0) begin
					run_kind = psp_pkg::RUN_WIDTH;
					width_seen = 1'b1;
					width_acc = times_ten_plus(16'd0, d);
				end
			end
			prev_cls = psp_pkg::CLS_DIGIT;
		end else if (b == psp_pkg::CH_DOT) begin
			dot_seen = 1'b1;
			prec_acc = '0;
			run_kind = psp_pkg::RUN_NONE;
			prev_cls = psp_pkg::CLS_DOT;
		end else begin
			case (b)
				psp_pkg::CH_HASH: flag_bits[psp_pkg::FLAG_HASH] = 1'b1;
				psp_pkg::CH_MINUS: flag_bits[psp_pkg::FLAG_MINUS] = 1'b1;
				psp_pkg::CH_PLUS: flag_bits[psp_pkg::FLAG_PLUS] = 1'b1;
				psp_pkg::CH_SPACE: flag_bits[psp_pkg::FLAG_SPACE] = 1'b1;
				psp_pkg::CH_H: begin
					letter_marks[psp_pkg::MARK_H_SEEN] = 1'b1;
					letter_marks[psp_pkg::MARK_H_ODD] = ~letter_marks[psp_pkg::MARK_H_ODD];
				end
				psp_pkg::CH_L: begin
					letter_marks[psp_pkg::MARK_L_SEEN] = 1'b1;
					letter_marks[psp_pkg::MARK_L_ODD] = ~letter_marks[psp_pkg::MARK_L_ODD];
				end
				psp_pkg::CH_J: letter_marks[psp_pkg::MARK_J_SEEN] = 1'b1;
				psp_pkg::CH_Z: letter_marks[psp_pkg::MARK_Z_SEEN] = 1'b1;
				default: ;
			endcase
			run_kind = psp_pkg::RUN_NONE;
			prev_cls = psp_pkg::CLS_OTHER;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(logic [7:0] b, logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		parse_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string body, logic [7:0] conv);
		for (int i = 0; i < body.len(); i++)
			send_item(body[i], 1'b0);
		send_item(conv, 1'b1);
	endtask

	function automatic logic [7:0] pick_from(string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	task automatic send_digits(int count);
		repeat (count)
			send_item(pick_from("0123456789"), 1'b0);
	endtask

	function automatic int digit_run_len();
		if ($urandom_range(0, 99) < 6)
			return $urandom_range(5, 7);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_random_spec();
		int n;
		if ($urandom_range(0, 99) < 15) begin
			n = $urandom_range(1, 8);
			repeat (n) begin
				if ($urandom_range(0, 1))
					send_item(pick_from("0123456789.#-+ hljz"), 1'b0);
				else
					send_item(8'($urandom_range(0, 255)), 1'b0);
			end
			if ($urandom_range(0, 1))
				send_item(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			repeat ($urandom_range(0, 3))
				send_item(pick_from("#-+ 0"), 1'b0);
			if ($urandom_range(0, 99) < 70)
				send_digits(digit_run_len());
			if ($urandom_range(0, 99) < 50) begin
				send_item(psp_pkg::CH_DOT, 1'b0);
				send_digits($urandom_range(0, 1) ? digit_run_len() : 0);
				if ($urandom_range(0, 99) < 10) begin
					send_item(psp_pkg::CH_DOT, 1'b0);
					send_digits($urandom_range(0, 2));
				end
			end
			case ($urandom_range(0, 7))
				0: ;
				1: send_item(psp_pkg::CH_H, 1'b0);
				2: send_text("hh", psp_pkg::CH_H);
				3: send_item(psp_pkg::CH_L, 1'b0);
				4: send_text("ll", psp_pkg::CH_L);
				5: send_item(psp_pkg::CH_J, 1'b0);
				6: send_item(psp_pkg::CH_Z, 1'b0);
				default: repeat ($urandom_range(1, 4))
					send_item(pick_from("hljz"), 1'b0);
			endcase
			if ($urandom_range(0, 99) < 70)
				send_item(pick_from("diouxXeEfFgGaAcspn%"), 1'b1);
			else
				send_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic test_flags();
		send_text("#-+ 0", "d");
	endtask

	task automatic test_saturation();
		send_text("99999.0", "g");
	endtask

	task automatic test_modifier_priority();
		send_text("hhz", psp_pkg::CH_DOT);
		send_text("jl", psp_pkg::CH_ZERO);
	endtask

	task automatic test_extreme_conversion();
		send_text("", 8'hFF);
		send_text("", 8'h00);
	endtask

	task automatic test_random_specs(int items, int send_pct, int recv_pct);
		int goal;
		goal = bytes_sent + items;
		send_gap_pct = send_pct;
		recv_gap_pct = recv_pct;
		while (bytes_sent < goal)
			send_random_spec();
	endtask

	task automatic test_output_backpressure();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		repeat (30)
			send_random_spec();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	task automatic flag_fault(string what, longint unsigned want, longint unsigned got);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic check_field(string what, longint unsigned want, longint unsigned got);
		if (want !== got)
			flag_fault(what, want, got);
	endtask

	always @(posedge clk) begin
		psp_pkg::result_t got;
		psp_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = psp_pkg::result_t'(m_axis_tdata[psp_pkg::RESULT_BITS-1:0]);
			results_checked++;
			if (spec_results_q.size() == 0) begin
				flag_fault("result with nothing pending", 64'd0, 64'(got));
			end else begin
				want = spec_results_q.pop_front();
				check_field("alt_form", 64'(want.alt_form), 64'(got.alt_form));
				check_field("left_justify", 64'(want.left_justify), 64'(got.left_justify));
				check_field("zero_pad", 64'(want.zero_pad), 64'(got.zero_pad));
				check_field("force_sign", 64'(want.force_sign), 64'(got.force_sign));
				check_field("space_sign", 64'(want.space_sign), 64'(got.space_sign));
				check_field("width", 64'(want.width), 64'(got.width));
				check_field("width_given", 64'(want.width_given), 64'(got.width_given));
				check_field("precision", 64'(want.precision), 64'(got.precision));
				check_field("precision_given", 64'(want.precision_given),
					64'(got.precision_given));
				check_field("size_modifier", 64'(want.size_modifier),
					64'(got.size_modifier));
				check_field("conversion", 64'(want.conversion), 64'(got.conversion));
				check_field("tdata fill", 64'd0,
					64'(m_axis_tdata[psp_pkg::TDATA_BITS-1:psp_pkg::RESULT_BITS]));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		clear_parse();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_flags();
		test_saturation();
		test_modifier_priority();
		test_extreme_conversion();
		test_random_specs(650, 11, 47);
		test_random_specs(650, 47, 11);
		test_output_backpressure();
		test_random_specs(650, 0, 0);

		s_axis_tvalid <= 1'b0;
		while (spec_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes forming %0d specifiers, checked %0d results.",
			bytes_sent, specs_sent, results_checked);
		$display("Covered flags, saturation, modifier priority, gaps and a long stall.");
		if (fault_count == 0 && spec_results_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", fault_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
